// ===== sv/zzdr_pkg.sv =====
// ----------------------------------------------------------------------------
// zzdr_pkg
// Shared types and constants for the zigzag diagonal reorder buffer.
// ----------------------------------------------------------------------------
package zzdr_pkg;

  // fixed field widths
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CFG_IDX_W = 1;

  // parameter defaults
  localparam int unsigned MAX_ROWS_DEF   = 8;
  localparam int unsigned MAX_COLS_DEF   = 8;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd1;

  localparam logic [CFG_W-1:0] NUM_ROWS_RST = 4'd8;
  localparam logic [CFG_W-1:0] NUM_COLS_RST = 4'd8;

  // controller to datapath
  typedef struct packed {
    logic load_wr;     // store the accepted word
    logic walk_start;  // rewind the walk to the top-left corner
    logic walk_rd;     // read the current walk position and step
    logic out_load;    // move read data into the output register
  } zzdr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic load_done;   // the word being stored completes the matrix
    logic rd_last;     // the pending read is the bottom-right element
    logic out_free;    // output register can take a new word
  } zzdr_status_t;

endpackage

// ===== sv/zzdr_ram.sv =====
// ----------------------------------------------------------------------------
// zzdr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module zzdr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/zzdr_ctrl.sv =====
// ----------------------------------------------------------------------------
// zzdr_ctrl
// Sequencer: loads words until the matrix is full, then steps the zigzag walk
// one read and one output load at a time.
// ----------------------------------------------------------------------------
module zzdr_ctrl
  import zzdr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         elem_valid_i,
  output logic         elem_ready_o,
  input  zzdr_status_t status_i,
  output zzdr_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_FILL
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_LOAD: begin
        if (elem_valid_i) begin
          cmd_o.load_wr = 1'b1;
          if (status_i.load_done) begin
            cmd_o.walk_start = 1'b1;
            state_d          = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.walk_rd = 1'b1;
        state_d       = ST_FILL;
      end
      ST_FILL: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = status_i.rd_last ? ST_LOAD : ST_READ;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assign elem_ready_o = (state_q == ST_LOAD);

endmodule

// ===== sv/zzdr_dp.sv =====
// ----------------------------------------------------------------------------
// zzdr_dp
// Datapath: size registers, load counter, zigzag walk position, matrix RAM
// and the output register.
// ----------------------------------------------------------------------------
module zzdr_dp
  import zzdr_pkg::*;
#(
  parameter int unsigned MAX_ROWS   = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS   = MAX_COLS_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic [VALUE_W-1:0]   elem_value_i,
  input  zzdr_cmd_t            cmd_i,
  output zzdr_status_t         status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [VALUE_W-1:0]   out_value_o,
  output logic [POS_W-1:0]     out_row_o,
  output logic [POS_W-1:0]     out_col_o,
  output logic                 out_last_o
);

  localparam int unsigned DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned STORE_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

  logic [CFG_W-1:0]   num_rows_q, num_cols_q;
  logic [CFG_W-1:0]   rows_eff, cols_eff;
  logic [ROW_W-1:0]   row_last;
  logic [COL_W-1:0]   col_last;
  logic [CNT_W-1:0]   total;
  logic [CNT_W-1:0]   load_cnt_q, load_cnt_d;
  logic [ROW_W-1:0]   walk_row_q, walk_row_d;
  logic [COL_W-1:0]   walk_col_q, walk_col_d;
  logic               walk_up_q, walk_up_d;
  logic [CNT_W-1:0]   walk_addr;
  logic [ROW_W-1:0]   rd_row_q;
  logic [COL_W-1:0]   rd_col_q;
  logic               rd_last_q;
  logic [STORE_W-1:0] rd_data;
  logic               out_valid_q;
  logic [VALUE_W-1:0] out_value_q;
  logic [POS_W-1:0]   out_row_q, out_col_q;
  logic               out_last_q;

  // sizes of zero count as one, oversized ones as the maximum
  always_comb begin
    if (num_rows_q == '0) begin
      rows_eff = CFG_W'(1);
    end else if (num_rows_q > CFG_W'(MAX_ROWS)) begin
      rows_eff = CFG_W'(MAX_ROWS);
    end else begin
      rows_eff = num_rows_q;
    end
    if (num_cols_q == '0) begin
      cols_eff = CFG_W'(1);
    end else if (num_cols_q > CFG_W'(MAX_COLS)) begin
      cols_eff = CFG_W'(MAX_COLS);
    end else begin
      cols_eff = num_cols_q;
    end
  end

  assign row_last  = ROW_W'(rows_eff - CFG_W'(1));
  assign col_last  = COL_W'(cols_eff - CFG_W'(1));
  assign total     = CNT_W'(CNT_W'(rows_eff) * CNT_W'(cols_eff));
  assign walk_addr = CNT_W'(CNT_W'(walk_row_q) * CNT_W'(cols_eff) + CNT_W'(walk_col_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= NUM_ROWS_RST;
      num_cols_q <= NUM_COLS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_NUM_ROWS: num_rows_q <= cfg_wdata_i;
        REG_NUM_COLS: num_cols_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // load counter, cleared by any size write and by the word that fills the matrix
  always_comb begin
    load_cnt_d = load_cnt_q;
    if (cfg_we_i) begin
      load_cnt_d = '0;
    end else if (cmd_i.load_wr) begin
      load_cnt_d = status_o.load_done ? '0 : CNT_W'(load_cnt_q + CNT_W'(1));
    end
  end

  // zigzag step
  always_comb begin
    walk_row_d = walk_row_q;
    walk_col_d = walk_col_q;
    walk_up_d  = walk_up_q;
    if (cmd_i.walk_start) begin
      walk_row_d = '0;
      walk_col_d = '0;
      walk_up_d  = 1'b1;
    end else if (cmd_i.walk_rd) begin
      if (walk_up_q) begin
        if (walk_row_q == '0 || walk_col_q == col_last) begin
          if (walk_col_q == col_last) begin
            walk_row_d = ROW_W'(walk_row_q + ROW_W'(1));
          end else begin
            walk_col_d = COL_W'(walk_col_q + COL_W'(1));
          end
          walk_up_d = 1'b0;
        end else begin
          walk_row_d = ROW_W'(walk_row_q - ROW_W'(1));
          walk_col_d = COL_W'(walk_col_q + COL_W'(1));
        end
      end else begin
        if (walk_col_q == '0 || walk_row_q == row_last) begin
          if (walk_row_q == row_last) begin
            walk_col_d = COL_W'(walk_col_q + COL_W'(1));
          end else begin
            walk_row_d = ROW_W'(walk_row_q + ROW_W'(1));
          end
          walk_up_d = 1'b1;
        end else begin
          walk_row_d = ROW_W'(walk_row_q + ROW_W'(1));
          walk_col_d = COL_W'(walk_col_q - COL_W'(1));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      walk_row_q <= '0;
      walk_col_q <= '0;
      walk_up_q  <= 1'b1;
    end else begin
      load_cnt_q <= load_cnt_d;
      walk_row_q <= walk_row_d;
      walk_col_q <= walk_col_d;
      walk_up_q  <= walk_up_d;
    end
  end

  // position of the read in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_last_q <= 1'b0;
    end else if (cmd_i.walk_rd) begin
      rd_last_q <= (walk_row_q == row_last) && (walk_col_q == col_last);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_rd) begin
      rd_row_q <= walk_row_q;
      rd_col_q <= walk_col_q;
    end
  end

  zzdr_ram #(
    .WIDTH (STORE_W),
    .DEPTH (DEPTH)
  ) u_matrix_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_wr),
    .waddr_i (load_cnt_q[AW-1:0]),
    .wdata_i (STORE_W'(elem_value_i)),
    .re_i    (cmd_i.walk_rd),
    .raddr_i (walk_addr[AW-1:0]),
    .rdata_o (rd_data)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q <= VALUE_W'(rd_data);
      out_row_q   <= POS_W'(rd_row_q);
      out_col_q   <= POS_W'(rd_col_q);
      out_last_q  <= rd_last_q;
    end
  end

  assign status_o.load_done = (CNT_W'(load_cnt_q + CNT_W'(1)) == total);
  assign status_o.rd_last   = rd_last_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== sv/zigzag_diagonal_reorder.sv =====
// ----------------------------------------------------------------------------
// zigzag_diagonal_reorder
// Reorder buffer: row-major matrix in, zigzag diagonal order out.
// ----------------------------------------------------------------------------
// Words arrive in row-major order and are written into a matrix RAM at one per
// cycle. The word that completes the num_rows by num_cols matrix starts a walk
// that emits every element in zigzag order with its row, its column and a last
// flag on the bottom-right element. Each emitted element takes one RAM read
// and then one load of the output register, as the matrix RAM has a single
// registered read port; the load waits while the output register is full.
// No input word is taken during the walk; the next load may start while the
// last element still waits in the output register. Sizes of zero act as one
// and sizes above the maximum act as the maximum; any size write restarts
// loading at the top-left element.
module zigzag_diagonal_reorder
  import zzdr_pkg::*;
#(
  parameter int unsigned MAX_ROWS   = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS   = MAX_COLS_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_wdata_i,
  input  logic                      elem_valid_i,
  output logic                      elem_ready_o,
  input  logic signed [VALUE_W-1:0] elem_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [VALUE_W-1:0] out_value_o,
  output logic [POS_W-1:0]          out_row_o,
  output logic [POS_W-1:0]          out_col_o,
  output logic                      out_last_o
);

  zzdr_cmd_t    cmd;
  zzdr_status_t status;

  zzdr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .elem_valid_i (elem_valid_i),
    .elem_ready_o (elem_ready_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  zzdr_dp #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .elem_value_i (elem_value_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_value_o  (out_value_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .out_last_o   (out_last_o)
  );

endmodule
